// ===== rtl/core/gre_pkg.sv =====
`timescale 1ns / 1ps

package gre_pkg;

  localparam int MAX_ROWS  = 32;
  localparam int MAX_COLS  = 64;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
  localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
  localparam int CFG_W     = 7;
  localparam int STEP_W    = 4;

  typedef logic [MAX_COLS-1:0] row_t;

  // configuration register indexes
  localparam logic CFG_ROWS_IN_USE = 1'b0;
  localparam logic CFG_COLS_IN_USE = 1'b1;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_FIND  = 1'b1;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_CELL_WR,
    ACT_SCAN_EVAL,
    ACT_EXT_EVAL,
    ACT_Y_TOP,
    ACT_CLR_WR,
    ACT_EMIT_HIT,
    ACT_EMIT_NONE
  } act_t;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_ITEM,
    COND_IS_FIND,
    COND_Y_END,
    COND_NO_HIT,
    COND_LEFT_SET,
    COND_Y_PAST,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic              rd;
    act_t              act;
    cond_t             cond;
    logic              hold;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic item;
    logic is_find;
    logic y_end;
    logic hit;
    logic left_set;
    logic y_past;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/gre_item_if.sv =====
`timescale 1ns / 1ps

interface gre_item_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [gre_pkg::ROW_W-1:0] cell_row;
  logic [gre_pkg::COL_W-1:0] cell_col;
  logic                      is_wall;

  modport source (output valid, kind, cell_row, cell_col, is_wall, input ready);
  modport sink (input valid, kind, cell_row, cell_col, is_wall, output ready);
endinterface

// ===== rtl/core/gre_rect_if.sv =====
`timescale 1ns / 1ps

interface gre_rect_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [gre_pkg::COL_W-1:0] rect_left;
  logic [gre_pkg::ROW_W-1:0] rect_top;
  logic [gre_pkg::COL_W-1:0] rect_right;
  logic [gre_pkg::ROW_W-1:0] rect_bottom;

  modport source (output valid, found, rect_left, rect_top, rect_right, rect_bottom,
                  input ready);
  modport sink (input valid, found, rect_left, rect_top, rect_right, rect_bottom,
                output ready);
endinterface

// ===== rtl/core/gre_grid.sv =====
`timescale 1ns / 1ps

module gre_grid (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic                      we,
  input  logic [gre_pkg::ROW_W-1:0] addr,
  input  gre_pkg::row_t             wdata,
  output gre_pkg::row_t             rdata
);

  gre_pkg::row_t                mem [gre_pkg::MAX_ROWS];
  logic [gre_pkg::MAX_ROWS-1:0] row_ok;
  gre_pkg::row_t                rd_q;
  logic                         rd_ok;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rd_q  <= mem[addr];
      rd_ok <= row_ok[addr];
    end
  end

  // a row never written since reset reads as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= '0;
    end else if (we) begin
      row_ok[addr] <= 1'b1;
    end
  end

  assign rdata = rd_ok ? rd_q : '0;

endmodule

// ===== rtl/core/gre_seq.sv =====
`timescale 1ns / 1ps

module gre_seq (
  input  logic              clk,
  input  logic              rst,
  input  gre_pkg::status_t  status,
  output gre_pkg::ucode_t   ctrl
);

  logic [gre_pkg::STEP_W-1:0] step;
  logic [gre_pkg::STEP_W-1:0] step_next;
  logic                       take;

  function automatic gre_pkg::ucode_t rom(input logic [gre_pkg::STEP_W-1:0] s);
    gre_pkg::ucode_t w;
    w = '{rd: 1'b0, act: gre_pkg::ACT_NONE, cond: gre_pkg::COND_ALWAYS, hold: 1'b0,
          target: gre_pkg::STEP_W'(0)};
    case (s)
      // wait for an item
      4'd0:  w = '{1'b0, gre_pkg::ACT_LOAD, gre_pkg::COND_ITEM, 1'b1, 4'd1};
      4'd1:  w = '{1'b0, gre_pkg::ACT_NONE, gre_pkg::COND_IS_FIND, 1'b0, 4'd4};
      // cell write: read row, merge bit
      4'd2:  w = '{1'b1, gre_pkg::ACT_NONE, gre_pkg::COND_NEVER, 1'b0, 4'd0};
      4'd3:  w = '{1'b0, gre_pkg::ACT_CELL_WR, gre_pkg::COND_ALWAYS, 1'b0, 4'd0};
      // raster scan for the corner
      4'd4:  w = '{1'b1, gre_pkg::ACT_NONE, gre_pkg::COND_Y_END, 1'b0, 4'd12};
      4'd5:  w = '{1'b0, gre_pkg::ACT_SCAN_EVAL, gre_pkg::COND_NO_HIT, 1'b0, 4'd4};
      // extend down, shrink right edge
      4'd6:  w = '{1'b1, gre_pkg::ACT_NONE, gre_pkg::COND_Y_PAST, 1'b0, 4'd8};
      4'd7:  w = '{1'b0, gre_pkg::ACT_EXT_EVAL, gre_pkg::COND_LEFT_SET, 1'b0, 4'd6};
      // clear pass
      4'd8:  w = '{1'b0, gre_pkg::ACT_Y_TOP, gre_pkg::COND_NEVER, 1'b0, 4'd0};
      4'd9:  w = '{1'b1, gre_pkg::ACT_NONE, gre_pkg::COND_Y_PAST, 1'b0, 4'd11};
      4'd10: w = '{1'b0, gre_pkg::ACT_CLR_WR, gre_pkg::COND_ALWAYS, 1'b0, 4'd9};
      // report
      4'd11: w = '{1'b0, gre_pkg::ACT_EMIT_HIT, gre_pkg::COND_OUT_FREE, 1'b1, 4'd0};
      4'd12: w = '{1'b0, gre_pkg::ACT_EMIT_NONE, gre_pkg::COND_OUT_FREE, 1'b1, 4'd0};
      default: w = '{1'b0, gre_pkg::ACT_NONE, gre_pkg::COND_ALWAYS, 1'b0, 4'd0};
    endcase
    return w;
  endfunction

  assign ctrl = rom(step);

  always_comb begin
    case (ctrl.cond)
      gre_pkg::COND_NEVER:    take = 1'b0;
      gre_pkg::COND_ALWAYS:   take = 1'b1;
      gre_pkg::COND_ITEM:     take = status.item;
      gre_pkg::COND_IS_FIND:  take = status.is_find;
      gre_pkg::COND_Y_END:    take = status.y_end;
      gre_pkg::COND_NO_HIT:   take = !status.hit;
      gre_pkg::COND_LEFT_SET: take = status.left_set;
      gre_pkg::COND_Y_PAST:   take = status.y_past;
      gre_pkg::COND_OUT_FREE: take = status.out_free;
      default:                take = 1'b1;
    endcase
  end

  always_comb begin
    if (take) begin
      step_next = ctrl.target;
    end else if (ctrl.hold) begin
      step_next = step;
    end else begin
      step_next = step + gre_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== rtl/core/gre_dpath.sv =====
`timescale 1ns / 1ps

module gre_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  gre_pkg::ucode_t               ctrl,
  input  logic [gre_pkg::ROW_CNT_W-1:0] nrows,
  input  logic [gre_pkg::COL_CNT_W-1:0] ncols,
  gre_item_if.sink                      item,
  gre_rect_if.source                    rect,
  output logic                          grid_rd,
  output logic                          grid_we,
  output logic [gre_pkg::ROW_W-1:0]     grid_addr,
  output gre_pkg::row_t                 grid_wdata,
  input  gre_pkg::row_t                 grid_rdata,
  output gre_pkg::status_t              status
);

  logic                          kind_r;
  logic                          wall_r;
  logic [gre_pkg::COL_W-1:0]     col_r;
  logic [gre_pkg::ROW_CNT_W-1:0] y;
  logic [gre_pkg::ROW_W-1:0]     top;
  logic [gre_pkg::ROW_W-1:0]     bottom;
  logic [gre_pkg::COL_W-1:0]     left;
  logic [gre_pkg::COL_W-1:0]     right;

  gre_pkg::row_t                 col_mask;
  gre_pkg::row_t                 up_mask;
  gre_pkg::row_t                 span_mask;
  gre_pkg::row_t                 scan_bits;
  gre_pkg::row_t                 gap_bits;
  gre_pkg::row_t                 cell_bit;
  logic [gre_pkg::COL_W-1:0]     first_set;
  logic [gre_pkg::COL_W-1:0]     first_gap;
  logic [gre_pkg::COL_CNT_W-1:0] gap_pos;
  logic [gre_pkg::COL_CNT_W-1:0] run_end;
  logic                          accept;
  logic                          out_free;

  function automatic logic [gre_pkg::COL_W-1:0] lowest_set(input gre_pkg::row_t v);
    logic [gre_pkg::COL_W-1:0] idx;
    idx = '0;
    for (int i = gre_pkg::MAX_COLS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = gre_pkg::COL_W'(i);
      end
    end
    return idx;
  endfunction

  assign accept     = item.valid && item.ready;
  assign item.ready = !rst && (ctrl.act == gre_pkg::ACT_LOAD);
  assign out_free   = !rect.valid || rect.ready;

  always_comb begin
    for (int i = 0; i < gre_pkg::MAX_COLS; i++) begin
      col_mask[i]  = (gre_pkg::COL_CNT_W'(i) < ncols);
      up_mask[i]   = (gre_pkg::COL_W'(i) >= left);
      span_mask[i] = (gre_pkg::COL_W'(i) >= left) && (gre_pkg::COL_W'(i) <= right);
    end
  end

  assign scan_bits = grid_rdata & col_mask;
  assign gap_bits  = ~grid_rdata & up_mask;
  assign first_set = lowest_set(scan_bits);
  assign first_gap = lowest_set(gap_bits);
  // no clear cell to the right means the run reaches the last column
  assign gap_pos   = (gap_bits == '0) ? gre_pkg::COL_CNT_W'(gre_pkg::MAX_COLS)
                                      : {1'b0, first_gap};
  assign run_end   = gap_pos - gre_pkg::COL_CNT_W'(1);
  assign cell_bit  = gre_pkg::row_t'(1) << col_r;

  assign grid_rd   = ctrl.rd;
  assign grid_addr = y[gre_pkg::ROW_W-1:0];
  assign grid_we   = (ctrl.act == gre_pkg::ACT_CELL_WR) || (ctrl.act == gre_pkg::ACT_CLR_WR);

  always_comb begin
    if (ctrl.act == gre_pkg::ACT_CELL_WR) begin
      grid_wdata = wall_r ? (grid_rdata | cell_bit) : (grid_rdata & ~cell_bit);
    end else begin
      grid_wdata = grid_rdata & ~span_mask;
    end
  end

  assign status.item     = accept;
  assign status.is_find  = (kind_r == gre_pkg::KIND_FIND);
  assign status.y_end    = (y >= nrows);
  assign status.hit      = (scan_bits != '0);
  assign status.left_set = grid_rdata[left];
  assign status.y_past   = (y > {1'b0, bottom});
  assign status.out_free = out_free;

  always_ff @(posedge clk) begin
    case (ctrl.act)
      gre_pkg::ACT_LOAD: begin
        if (accept) begin
          kind_r <= item.kind;
          wall_r <= item.is_wall;
          col_r  <= item.cell_col;
          y      <= (item.kind == gre_pkg::KIND_FIND) ? '0 : {1'b0, item.cell_row};
          right  <= gre_pkg::COL_W'(ncols - gre_pkg::COL_CNT_W'(1));
          bottom <= gre_pkg::ROW_W'(nrows - gre_pkg::ROW_CNT_W'(1));
        end
      end
      gre_pkg::ACT_SCAN_EVAL: begin
        if (status.hit) begin
          left <= first_set;
          top  <= y[gre_pkg::ROW_W-1:0];
        end else begin
          y <= y + gre_pkg::ROW_CNT_W'(1);
        end
      end
      gre_pkg::ACT_EXT_EVAL: begin
        if (status.left_set) begin
          if (run_end < {1'b0, right}) begin
            right <= run_end[gre_pkg::COL_W-1:0];
          end
          y <= y + gre_pkg::ROW_CNT_W'(1);
        end else begin
          bottom <= gre_pkg::ROW_W'(y - gre_pkg::ROW_CNT_W'(1));
        end
      end
      gre_pkg::ACT_Y_TOP: begin
        y <= {1'b0, top};
      end
      gre_pkg::ACT_CLR_WR: begin
        y <= y + gre_pkg::ROW_CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rect.valid <= 1'b0;
    end else if (out_free && ((ctrl.act == gre_pkg::ACT_EMIT_HIT) ||
                              (ctrl.act == gre_pkg::ACT_EMIT_NONE))) begin
      rect.valid <= 1'b1;
    end else if (rect.ready) begin
      rect.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && (ctrl.act == gre_pkg::ACT_EMIT_HIT)) begin
      rect.found       <= 1'b1;
      rect.rect_left   <= left;
      rect.rect_top    <= top;
      rect.rect_right  <= right;
      rect.rect_bottom <= bottom;
    end else if (out_free && (ctrl.act == gre_pkg::ACT_EMIT_NONE)) begin
      rect.found       <= 1'b0;
      rect.rect_left   <= '0;
      rect.rect_top    <= '0;
      rect.rect_right  <= '0;
      rect.rect_bottom <= '0;
    end
  end

endmodule

// ===== rtl/core/greedy_rectangle_extractor_unit.sv =====
`timescale 1ns / 1ps
// Cell write: the row is read, the cell bit merged and the row written back, with no
// result transaction. Find: a corner scan reads rows 0..top, an extension reads rows
// top..bottom until a clear left cell or the last row ends it, a clear pass rewrites
// rows top..bottom, and the result is emitted once the output register is free.
// Synchronous reset idles the sequencer, empties the grid through per-row valid
// bits at once, and loads rows_in_use = 32, cols_in_use = 64.
module greedy_rectangle_extractor_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [gre_pkg::CFG_W-1:0] cfg_data,
  gre_item_if.sink                  item,
  gre_rect_if.source                rect
);

  // Configuration registers; the user writes them only while the unit is idle, not enforced here.
  logic [gre_pkg::ROW_CNT_W-1:0] rows_in_use;
  logic [gre_pkg::COL_CNT_W-1:0] cols_in_use;

  // Region actually searched: register values clamped to the grid size.
  logic [gre_pkg::ROW_CNT_W-1:0] nrows;
  logic [gre_pkg::COL_CNT_W-1:0] ncols;

  gre_pkg::ucode_t               ctrl;
  gre_pkg::status_t              status;
  logic                          grid_rd;
  logic                          grid_we;
  logic [gre_pkg::ROW_W-1:0]     grid_addr;
  gre_pkg::row_t                 grid_wdata;
  gre_pkg::row_t                 grid_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= gre_pkg::ROW_CNT_W'(gre_pkg::MAX_ROWS);
      cols_in_use <= gre_pkg::COL_CNT_W'(gre_pkg::MAX_COLS);
    end else if (cfg_we) begin
      case (cfg_index)
        gre_pkg::CFG_ROWS_IN_USE: rows_in_use <= cfg_data[gre_pkg::ROW_CNT_W-1:0];
        gre_pkg::CFG_COLS_IN_USE: cols_in_use <= cfg_data[gre_pkg::COL_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A zero row count leaves an empty region: the scan ends at once with no hit; a zero column count also gives no hit.
  assign nrows = (rows_in_use > gre_pkg::ROW_CNT_W'(gre_pkg::MAX_ROWS))
                 ? gre_pkg::ROW_CNT_W'(gre_pkg::MAX_ROWS) : rows_in_use;
  assign ncols = (cols_in_use > gre_pkg::COL_CNT_W'(gre_pkg::MAX_COLS))
                 ? gre_pkg::COL_CNT_W'(gre_pkg::MAX_COLS) : cols_in_use;

  // Step counter and control store: one control word per cycle, held on a wait step
  // until its condition is met, with conditional jumps on datapath status.
  gre_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // Row registers, bit searches, masks and the result register.
  gre_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .nrows      (nrows),
    .ncols      (ncols),
    .item       (item),
    .rect       (rect),
    .grid_rd    (grid_rd),
    .grid_we    (grid_we),
    .grid_addr  (grid_addr),
    .grid_wdata (grid_wdata),
    .grid_rdata (grid_rdata),
    .status     (status)
  );

  // Occupancy grid, one word per row; writes are read-modify-write over two control
  // steps and scans only read, so one shared address suffices.
  gre_grid u_grid (
    .clk   (clk),
    .rst   (rst),
    .rd_en (grid_rd),
    .we    (grid_we),
    .addr  (grid_addr),
    .wdata (grid_wdata),
    .rdata (grid_rdata)
  );

endmodule
